// File: rtl/vpcc_pkg.sv
// Package: types and constants for the virtio PCI common-config register block.
package vpcc_pkg;

  localparam int unsigned MaxQueuesDef      = 8;
  localparam int unsigned QueueSizeLimitDef = 32768;

  localparam logic [1:0] OpRead    = 2'd0;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpCfgChg  = 2'd2;

  localparam logic [1:0] IrqNone   = 2'd0;
  localparam logic [1:0] IrqMsix   = 2'd1;
  localparam logic [1:0] IrqLegacy = 2'd2;

  localparam logic [13:0] IsrOff    = 14'h1000;
  localparam logic [13:0] DevCfgOff = 14'h2000;
  localparam logic [13:0] NotifyOff = 14'h3000;
  localparam logic [13:0] CommonLen = 14'd56;

  localparam logic [15:0] NoVec = 16'hFFFF;
  localparam int unsigned StDriverOk   = 2;
  localparam int unsigned StFeaturesOk = 3;
  localparam int unsigned StNeedsReset = 6;

  localparam logic [63:0] FVersion1   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] OfferedMask = 64'hFFFC_0001_30FF_FFFF;

  // common-config register offsets
  localparam logic [5:0] RegDevSel   = 6'd0;
  localparam logic [5:0] RegDevFeat  = 6'd4;
  localparam logic [5:0] RegDrvSel   = 6'd8;
  localparam logic [5:0] RegDrvFeat  = 6'd12;
  localparam logic [5:0] RegCfgVec   = 6'd16;
  localparam logic [5:0] RegNumQ     = 6'd18;
  localparam logic [5:0] RegStatus   = 6'd20;
  localparam logic [5:0] RegGen      = 6'd21;
  localparam logic [5:0] RegQSel     = 6'd22;
  localparam logic [5:0] RegQSize    = 6'd24;
  localparam logic [5:0] RegQVec     = 6'd26;
  localparam logic [5:0] RegQEn      = 6'd28;
  localparam logic [5:0] RegQNotOff  = 6'd30;
  localparam logic [5:0] RegDescLo   = 6'd32;
  localparam logic [5:0] RegDescHi   = 6'd36;
  localparam logic [5:0] RegAvailLo  = 6'd40;
  localparam logic [5:0] RegAvailHi  = 6'd44;
  localparam logic [5:0] RegUsedLo   = 6'd48;
  localparam logic [5:0] RegUsedHi   = 6'd52;

  localparam logic [2:0] CfgHostFeat = 3'd0;
  localparam logic [2:0] CfgNumQ     = 3'd1;
  localparam logic [2:0] CfgQMax     = 3'd2;
  localparam logic [2:0] CfgMsixCnt  = 3'd3;
  localparam logic [2:0] CfgDevCfg   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [13:0] offset;
    logic [3:0]  access_bytes;
    logic [31:0] write_data;
    logic        msix_on;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  irq_kind;
    logic [10:0] irq_vector;
    logic        intx_level;
    logic        notify_valid;
    logic [15:0] notify_queue;
    logic        device_reset;
    logic        features_accepted;
    logic [63:0] negotiated_features;
  } rsp_t;

endpackage

// File: rtl/virtio_pci_common_config_regs.sv
// Top level: virtio modern PCI common-config register block.
// One BAR transaction (read, write or config-changed event) is taken per cycle while
// the output does not stall; its response leaves from an output register. The request
// register and the response register are the only stages, so a stall on the output
// stalls the input. Queue state sits in flip-flops, MAX_QUEUES entries. Config writes
// take effect at once; queue_size_max also sets queue sizes at the next device reset.
module virtio_pci_common_config_regs #(
  parameter int unsigned MAX_QUEUES       = vpcc_pkg::MaxQueuesDef,
  parameter int unsigned QUEUE_SIZE_LIMIT = vpcc_pkg::QueueSizeLimitDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vpcc_pkg::req_t     in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vpcc_pkg::rsp_t     out_data_o
);

  localparam int unsigned QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam logic [15:0] QLim = 16'(QUEUE_SIZE_LIMIT);
  localparam logic [15:0] NQ   = 16'(MAX_QUEUES);
  // queue size after reset: default queue_size_max of 256, capped at the limit
  localparam logic [15:0] QRst = (QLim < 16'd256) ? QLim : 16'd256;

  // configuration
  logic [63:0] host_feat_q;
  logic [3:0]  num_q_q;
  logic [15:0] qmax_cfg_q;
  logic [11:0] msix_cnt_q;
  logic [12:0] devcfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_feat_q <= '0;
      num_q_q     <= 4'd1;
      qmax_cfg_q  <= 16'd256;
      msix_cnt_q  <= '0;
      devcfg_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vpcc_pkg::CfgHostFeat: host_feat_q <= cfg_data_i;
        vpcc_pkg::CfgNumQ:     num_q_q     <= cfg_data_i[3:0];
        vpcc_pkg::CfgQMax:     qmax_cfg_q  <= cfg_data_i[15:0];
        vpcc_pkg::CfgMsixCnt:  msix_cnt_q  <= cfg_data_i[11:0];
        vpcc_pkg::CfgDevCfg:   devcfg_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // input register
  logic           req_v_q;
  vpcc_pkg::req_t req_q;
  logic           adv;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
    end else if (adv) begin
      req_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  // state
  logic [63:0] drv_feat_q, drv_feat_d;
  logic [31:0] dev_sel_q, dev_sel_d, drv_sel_q, drv_sel_d;
  logic [7:0]  status_q, status_d, gen_q, gen_d, isr_q, isr_d;
  logic        line_q, line_d;
  logic [15:0] cfg_vec_q, cfg_vec_d, qsel_q, qsel_d;
  logic [15:0] qsize_q [MAX_QUEUES];
  logic [15:0] qsize_d [MAX_QUEUES];
  logic [15:0] qvec_q  [MAX_QUEUES];
  logic [15:0] qvec_d  [MAX_QUEUES];
  logic        qen_q   [MAX_QUEUES];
  logic        qen_d   [MAX_QUEUES];
  logic [63:0] desc_q  [MAX_QUEUES];
  logic [63:0] desc_d  [MAX_QUEUES];
  logic [63:0] avail_q [MAX_QUEUES];
  logic [63:0] avail_d [MAX_QUEUES];
  logic [63:0] used_q  [MAX_QUEUES];
  logic [63:0] used_d  [MAX_QUEUES];

  vpcc_pkg::rsp_t rsp_d;

  // derived values
  logic [63:0] offered;
  logic [15:0] nq, qmax, vcnt;
  logic [12:0] dcfg;
  logic        qv;
  logic [QW-1:0] qi;
  logic [31:0] v;
  logic [5:0]  co;
  logic [3:0]  sz;
  logic        sz1, sz2, sz4;
  logic [63:0] bad;
  logic [15:0] vfilt;
  logic [15:0] cur_size;
  logic [63:0] cur_desc, cur_avail, cur_used, ring;
  logic [14:0] dc_end;
  logic        dc_hit;
  logic [63:0] mask64, fsh;

  assign offered = (host_feat_q & vpcc_pkg::OfferedMask) | vpcc_pkg::FVersion1;
  assign nq   = ({12'd0, num_q_q} > NQ) ? NQ : {12'd0, num_q_q};
  assign qmax = (qmax_cfg_q > QLim) ? QLim : qmax_cfg_q;
  assign vcnt = (msix_cnt_q > 12'd2048) ? 16'd2048 : {4'd0, msix_cnt_q};
  assign dcfg = (devcfg_q > 13'h1000) ? 13'h1000 : devcfg_q;
  assign qv   = qsel_q < nq;
  assign qi   = qsel_q[QW-1:0];
  assign sz   = req_q.access_bytes;
  assign sz1  = sz == 4'd1;
  assign sz2  = sz == 4'd2;
  assign sz4  = sz == 4'd4;
  assign v    = sz1 ? {24'd0, req_q.write_data[7:0]} :
                sz2 ? {16'd0, req_q.write_data[15:0]} : req_q.write_data;
  assign co   = req_q.offset[5:0];
  assign bad  = sz1 ? 64'hFF : sz2 ? 64'hFFFF : sz4 ? 64'hFFFF_FFFF : '1;
  assign vfilt = (v[15:0] == vpcc_pkg::NoVec || (v[31:16] == '0 && v[15:0] < vcnt)) ?
                 v[15:0] : vpcc_pkg::NoVec;
  assign cur_size  = qsize_q[qi];
  assign cur_desc  = desc_q[qi];
  assign cur_avail = avail_q[qi];
  assign cur_used  = used_q[qi];
  assign ring = (co < vpcc_pkg::RegAvailLo) ? cur_desc :
                (co < vpcc_pkg::RegUsedLo) ? cur_avail : cur_used;
  assign dc_end = {1'b0, req_q.offset} + {11'd0, sz};
  assign dc_hit = req_q.offset >= vpcc_pkg::DevCfgOff &&
                  dc_end <= {1'b0, vpcc_pkg::DevCfgOff} + {2'd0, dcfg} &&
                  (sz1 || sz2 || sz4) &&
                  ((req_q.offset[1:0] & (sz[1:0] - 2'd1)) == 2'd0);
  assign mask64 = drv_sel_q[0] ? 64'hFFFF_FFFF_0000_0000 : 64'h0000_0000_FFFF_FFFF;
  assign fsh    = drv_sel_q[0] ? {v, 32'd0} : {32'd0, v};

  function automatic logic pow2(input logic [15:0] s);
    pow2 = (s != '0) && ((s & (s - 16'd1)) == '0);
  endfunction

  always_comb begin
    logic [7:0] st;
    logic       rst_pulse;
    logic       cfg_irq;
    logic [63:0] rd;

    drv_feat_d = drv_feat_q; dev_sel_d = dev_sel_q; drv_sel_d = drv_sel_q;
    status_d = status_q; gen_d = gen_q; isr_d = isr_q; line_d = line_q;
    cfg_vec_d = cfg_vec_q; qsel_d = qsel_q;
    qsize_d = qsize_q; qvec_d = qvec_q; qen_d = qen_q;
    desc_d = desc_q; avail_d = avail_q; used_d = used_q;
    rsp_d = '0;
    st = v[7:0];
    rst_pulse = 1'b0;
    cfg_irq = 1'b0;
    rd = bad;

    if (req_v_q) begin
      unique case (req_q.opcode)
        vpcc_pkg::OpRead: begin
          if (req_q.offset < vpcc_pkg::CommonLen) begin
            unique case (co)
              vpcc_pkg::RegDevSel:  if (sz4) rd = {32'd0, dev_sel_q};
              vpcc_pkg::RegDevFeat: if (sz4) rd = (dev_sel_q == 32'd0) ? {32'd0, offered[31:0]} :
                                                (dev_sel_q == 32'd1) ? {32'd0, offered[63:32]} : '0;
              vpcc_pkg::RegDrvSel:  if (sz4) rd = {32'd0, drv_sel_q};
              vpcc_pkg::RegDrvFeat: if (sz4) rd = (drv_sel_q == 32'd0) ? {32'd0, drv_feat_q[31:0]} :
                                                (drv_sel_q == 32'd1) ? {32'd0, drv_feat_q[63:32]} : '0;
              vpcc_pkg::RegCfgVec:  if (sz2) rd = {48'd0, cfg_vec_q};
              vpcc_pkg::RegNumQ:    if (sz2) rd = {48'd0, nq};
              vpcc_pkg::RegStatus:  if (sz1) rd = {56'd0, status_q};
              vpcc_pkg::RegGen:     if (sz1) rd = {56'd0, gen_q};
              vpcc_pkg::RegQSel:    if (sz2) rd = {48'd0, qsel_q};
              vpcc_pkg::RegQSize:   if (sz2) rd = qv ? {48'd0, cur_size} : '0;
              vpcc_pkg::RegQVec:    if (sz2) rd = {48'd0, qv ? qvec_q[qi] : vpcc_pkg::NoVec};
              vpcc_pkg::RegQEn:     if (sz2) rd = {63'd0, qv & qen_q[qi]};
              vpcc_pkg::RegQNotOff: if (sz2) rd = '0;
              vpcc_pkg::RegDescLo, vpcc_pkg::RegDescHi, vpcc_pkg::RegAvailLo,
              vpcc_pkg::RegAvailHi, vpcc_pkg::RegUsedLo, vpcc_pkg::RegUsedHi:
                if (sz4) rd = !qv ? '0 : co[2] ? {32'd0, ring[63:32]} : {32'd0, ring[31:0]};
              default: ;
            endcase
          end else if (req_q.offset == vpcc_pkg::IsrOff && sz1) begin
            rd = {56'd0, isr_q};
            isr_d = '0;
            if (isr_q != '0) line_d = 1'b0;
          end else if (dc_hit) begin
            rd = '0;
          end
          rsp_d.read_data = rd;
        end
        vpcc_pkg::OpWrite: begin
          if (req_q.offset < vpcc_pkg::CommonLen) begin
            unique case (co)
              vpcc_pkg::RegDevSel: if (sz4) dev_sel_d = v;
              vpcc_pkg::RegDrvSel: if (sz4) drv_sel_d = v;
              vpcc_pkg::RegDrvFeat:
                if (sz4 && drv_sel_q < 32'd2 && !status_q[vpcc_pkg::StFeaturesOk])
                  drv_feat_d = (drv_feat_q & ~mask64) | (fsh & offered);
              vpcc_pkg::RegCfgVec: if (sz2) cfg_vec_d = vfilt;
              vpcc_pkg::RegStatus: if (sz1) begin
                if (st == '0) begin
                  rst_pulse = 1'b1;
                end else begin
                  if (!drv_feat_q[32]) st[vpcc_pkg::StFeaturesOk] = 1'b0;
                  st[vpcc_pkg::StNeedsReset] = st[vpcc_pkg::StNeedsReset] |
                                               status_q[vpcc_pkg::StNeedsReset];
                  status_d = st;
                  if (!status_q[vpcc_pkg::StFeaturesOk] && st[vpcc_pkg::StFeaturesOk]) begin
                    rsp_d.features_accepted   = 1'b1;
                    rsp_d.negotiated_features = drv_feat_q;
                  end
                end
              end
              vpcc_pkg::RegQSel: if (sz2) qsel_d = v[15:0];
              vpcc_pkg::RegQSize:
                if (sz2 && qv && !qen_q[qi] && pow2(v[15:0]) && v[15:0] <= qmax)
                  qsize_d[qi] = v[15:0];
              vpcc_pkg::RegQVec: if (sz2 && qv) qvec_d[qi] = vfilt;
              vpcc_pkg::RegQEn:
                if (sz2 && v == 32'd1 && qv && !qen_q[qi]) begin
                  if (pow2(cur_size) && cur_desc[3:0] == '0 && !cur_avail[0] &&
                      cur_used[1:0] == '0) begin
                    qen_d[qi] = 1'b1;
                  end else if (!status_q[vpcc_pkg::StNeedsReset]) begin
                    status_d[vpcc_pkg::StNeedsReset] = 1'b1;
                    cfg_irq = status_q[vpcc_pkg::StDriverOk];
                  end
                end
              vpcc_pkg::RegDescLo, vpcc_pkg::RegDescHi:
                if (sz4 && qv && !qen_q[qi]) begin
                  if (co[2]) desc_d[qi][63:32] = v; else desc_d[qi][31:0] = v;
                end
              vpcc_pkg::RegAvailLo, vpcc_pkg::RegAvailHi:
                if (sz4 && qv && !qen_q[qi]) begin
                  if (co[2]) avail_d[qi][63:32] = v; else avail_d[qi][31:0] = v;
                end
              vpcc_pkg::RegUsedLo, vpcc_pkg::RegUsedHi:
                if (sz4 && qv && !qen_q[qi]) begin
                  if (co[2]) used_d[qi][63:32] = v; else used_d[qi][31:0] = v;
                end
              default: ;
            endcase
          end else if (req_q.offset == vpcc_pkg::NotifyOff && sz2) begin
            rsp_d.notify_valid = 1'b1;
            rsp_d.notify_queue = v[15:0];
          end
        end
        vpcc_pkg::OpCfgChg: begin
          gen_d   = gen_q + 8'd1;
          cfg_irq = 1'b1;
        end
        default: ;
      endcase

      if (cfg_irq) begin
        if (req_q.msix_on) begin
          if (cfg_vec_q != vpcc_pkg::NoVec) begin
            rsp_d.irq_kind   = vpcc_pkg::IrqMsix;
            rsp_d.irq_vector = cfg_vec_q[10:0];
          end
        end else begin
          isr_d[1] = 1'b1;
          line_d   = 1'b1;
          rsp_d.irq_kind = vpcc_pkg::IrqLegacy;
        end
      end

      if (rst_pulse) begin
        drv_feat_d = '0; dev_sel_d = '0; drv_sel_d = '0; status_d = '0;
        isr_d = '0; line_d = 1'b0; cfg_vec_d = vpcc_pkg::NoVec; qsel_d = '0;
        for (int i = 0; i < MAX_QUEUES; i++) begin
          qsize_d[i] = qmax; qvec_d[i] = vpcc_pkg::NoVec; qen_d[i] = 1'b0;
          desc_d[i] = '0; avail_d[i] = '0; used_d[i] = '0;
        end
        rsp_d.device_reset = 1'b1;
      end
      rsp_d.intx_level = line_d;
    end
  end

  logic upd;
  assign upd = adv && req_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_feat_q <= '0; dev_sel_q <= '0; drv_sel_q <= '0; status_q <= '0;
      gen_q <= '0; isr_q <= '0; line_q <= 1'b0; cfg_vec_q <= vpcc_pkg::NoVec;
      qsel_q <= '0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        qsize_q[i] <= QRst; qvec_q[i] <= vpcc_pkg::NoVec; qen_q[i] <= 1'b0;
        desc_q[i] <= '0; avail_q[i] <= '0; used_q[i] <= '0;
      end
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= req_v_q;
      if (upd) begin
        drv_feat_q <= drv_feat_d; dev_sel_q <= dev_sel_d; drv_sel_q <= drv_sel_d;
        status_q <= status_d; gen_q <= gen_d; isr_q <= isr_d; line_q <= line_d;
        cfg_vec_q <= cfg_vec_d; qsel_q <= qsel_d;
        qsize_q <= qsize_d; qvec_q <= qvec_d; qen_q <= qen_d;
        desc_q <= desc_d; avail_q <= avail_d; used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_data_o <= rsp_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.irq_kind == vpcc_pkg::IrqLegacy |-> out_data_o.intx_level)
    else $error("legacy interrupt without line asserted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.device_reset |-> !out_data_o.features_accepted &&
    status_q == '0)
    else $error("device reset left status set");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.features_accepted |-> out_data_o.negotiated_features[32])
    else $error("features accepted without the version feature bit");

endmodule
